// ----- src/pulse_oximeter_bpm_spo2_estimator_core_defines.svh -----
// Assertion macros shared by the estimator modules.
`ifndef PULSE_OXIMETER_BPM_SPO2_ESTIMATOR_CORE_DEFINES_SVH
`define PULSE_OXIMETER_BPM_SPO2_ESTIMATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define POXE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define POXE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define POXE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define POXE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- src/poxe_pkg.sv -----
package poxe_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam int ELAPSED_W = 23;
   localparam int BPM_W     = 10;
   localparam int SPO2_W    = 7;

   localparam int MS_PER_S      = 1000;
   localparam int HALF_S_MS     = 500;
   localparam int ENV_MIN_RESET = 100000;
   localparam int SPO2_BASE     = 104;
   localparam int SEC_PER_MIN   = 60;
   localparam int AC_MIN        = 10;
   localparam int BPM_MAX       = 1023;
   localparam int BPM_MIN_S     = 3;
   localparam int BEAT_MAX      = 65535;
   localparam int BEAT60_W      = 22;
   localparam int TIME_W        = 32;

   // ceil(2^38 / 1000): exact x/1000 at bit 38 and x/500 at bit 37 for any 32-bit x
   localparam logic [31:0] MS_RECIP     = 32'd274877907;
   localparam int          RECIP_W      = 61;
   localparam int          SEC_SHIFT    = 38;
   localparam int          HALF_S_SHIFT = 37;

   localparam logic [17:0] NO_FINGER_RST  = 18'd23500;
   localparam logic [6:0]  SPO2_LIMIT_RST = 7'd95;
   localparam logic [5:0]  PULSE_LOW_RST  = 6'd50;
   localparam logic [6:0]  PULSE_HIGH_RST = 7'd100;
   localparam logic [15:0] WINDOW_MS_RST  = 16'd2500;
   localparam logic [11:0] HYST_RST       = 12'd15;
   localparam logic [7:0]  MEASURE_S_RST  = 8'd60;

   typedef enum logic [2:0] {
      REG_NO_FINGER  = 3'd0,
      REG_SPO2_LIMIT = 3'd1,
      REG_PULSE_LOW  = 3'd2,
      REG_PULSE_HIGH = 3'd3,
      REG_WINDOW_MS  = 3'd4,
      REG_HYSTERESIS = 3'd5,
      REG_MEASURE_S  = 3'd6
   } poxe_reg_type;

   typedef enum logic [1:0] {
      ST_NO_FINGER = 2'd0,
      ST_MEASURING = 2'd1,
      ST_FINISHED  = 2'd2
   } poxe_status_type;

   typedef enum logic [1:0] {
      ALARM_NONE   = 2'd0,
      ALARM_LOW_O2 = 2'd1,
      ALARM_PULSE  = 2'd2
   } poxe_alarm_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_FRONT,
      OP_EVAL,
      OP_BPM,
      OP_WIN,
      OP_MUL1,
      OP_MUL2,
      OP_CMP,
      OP_SPO2,
      OP_TONE,
      OP_OUT
   } poxe_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FRONT,
      S_EL_WAIT,
      S_EVAL,
      S_BPM_WAIT,
      S_BPM,
      S_WIN,
      S_MUL1,
      S_MUL2,
      S_CMP,
      S_SPO2_WAIT,
      S_SPO2,
      S_TONE_WAIT,
      S_TONE,
      S_OUT
   } poxe_state_type;

   typedef struct packed {
      poxe_op_type op;
   } poxe_cmd_type;

   typedef struct packed {
      logic no_finger;
      logic measuring;
      logic need_bpm;
      logic win_close;
      logic spo2_calc;
      logic spo2_sat;
      logic div_busy;
   } poxe_stat_type;

endpackage

// ----- src/poxe_if.sv -----
interface poxe_req_if #(parameter int SAMPLE_BITS = 18) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] ir_sample;
   logic [SAMPLE_BITS-1:0] red_sample;
   logic [31:0]            now_ms;
   modport source (output valid, ir_sample, red_sample, now_ms, input ready);
   modport sink   (input valid, ir_sample, red_sample, now_ms, output ready);
endinterface

interface poxe_rsp_if ();
   import poxe_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [ELAPSED_W-1:0] elapsed_seconds;
   logic [BPM_W-1:0]     pulse_bpm;
   logic [SPO2_W-1:0]    oxygen_percent;
   logic                 beat_detected;
   logic [1:0]           alarm_kind;
   logic                 alarm_tone_on;
   logic                 session_done;
   modport source (output valid, status, elapsed_seconds, pulse_bpm, oxygen_percent,
                   beat_detected, alarm_kind, alarm_tone_on, session_done, input ready);
   modport sink   (input valid, status, elapsed_seconds, pulse_bpm, oxygen_percent,
                   beat_detected, alarm_kind, alarm_tone_on, session_done, output ready);
endinterface

interface poxe_csr_if ();
   import poxe_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/poxe_div.sv -----
`include "pulse_oximeter_bpm_spo2_estimator_core_defines.svh"
module poxe_div #(
   parameter int DW = 42,
   parameter int VW = 36,
   parameter int CW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   input  logic [CW-1:0] steps,
   output logic          busy,
   output logic [DW-1:0] quotient
);
   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [DW-1:0] q_ff, q_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW:0]   trial, diff;
   logic          fits;

   // one quotient bit per cycle, dividend enters msb first
   assign trial = {rem_ff, dvd_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         dvd_in  = dividend;
         dvs_in  = divisor;
         q_in    = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = dvd_ff << 1;
         q_in    = {q_ff[DW-2:0], fits};
         rem_in  = fits ? diff[VW-1:0] : trial[VW-1:0];
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign quotient  = q_ff;

   `POXE_ASSERT_IMP(a_start_idle, clock, reset, start, !busy_ff)
   `POXE_ASSERT_NXT(a_start_busy, clock, reset, start, busy_ff)
   `POXE_ASSERT_NXT(a_last_step, clock, reset, busy_ff && !start && cnt_ff == CW'(1), !busy_ff)
endmodule

// ----- src/poxe_ctrl.sv -----
`include "pulse_oximeter_bpm_spo2_estimator_core_defines.svh"
module poxe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output poxe_pkg::poxe_cmd_type  cmd,
   input  poxe_pkg::poxe_stat_type stat
);
   import poxe_pkg::*;

   poxe_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_FRONT;
            end
         end
         S_FRONT: begin
            cmd.op   = OP_FRONT;
            state_in = stat.no_finger ? S_OUT : S_EL_WAIT;
         end
         S_EL_WAIT: if (!stat.div_busy) state_in = S_EVAL;
         S_EVAL: begin
            cmd.op = OP_EVAL;
            if (!stat.measuring) state_in = S_TONE_WAIT;
            else if (stat.need_bpm) state_in = S_BPM_WAIT;
            else state_in = S_WIN;
         end
         S_BPM_WAIT: if (!stat.div_busy) state_in = S_BPM;
         S_BPM: begin
            cmd.op   = OP_BPM;
            state_in = S_WIN;
         end
         S_WIN: begin
            cmd.op   = OP_WIN;
            state_in = (stat.win_close && stat.spo2_calc) ? S_MUL1 : S_OUT;
         end
         S_MUL1: begin
            cmd.op   = OP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op   = OP_MUL2;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.op   = OP_CMP;
            state_in = stat.spo2_sat ? S_OUT : S_SPO2_WAIT;
         end
         S_SPO2_WAIT: if (!stat.div_busy) state_in = S_SPO2;
         S_SPO2: begin
            cmd.op   = OP_SPO2;
            state_in = S_OUT;
         end
         S_TONE_WAIT: if (!stat.div_busy) state_in = S_TONE;
         S_TONE: begin
            cmd.op   = OP_TONE;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.op == OP_OUT) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   `POXE_ASSERT_NXT(a_out_valid, clock, reset, cmd.op == OP_OUT, rsp_valid_ff)
   `POXE_ASSERT_NXT(a_accept_front, clock, reset, req_valid && req_ready, state_ff == S_FRONT)
   `POXE_ASSERT_NXT(a_el_done, clock, reset, state_ff == S_EL_WAIT && !stat.div_busy,
                    state_ff == S_EVAL)
endmodule

// ----- src/poxe_dp.sv -----
module poxe_dp #(
   parameter int SAMPLE_BITS = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   input  poxe_pkg::poxe_cmd_type              cmd,
   output poxe_pkg::poxe_stat_type             stat,
   input  logic [SAMPLE_BITS-1:0]              ir_sample,
   input  logic [SAMPLE_BITS-1:0]              red_sample,
   input  logic [31:0]                         now_ms,
   input  logic                                csr_write,
   input  logic [poxe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [poxe_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic [1:0]                          status,
   output logic [poxe_pkg::ELAPSED_W-1:0]      elapsed_seconds,
   output logic [poxe_pkg::BPM_W-1:0]          pulse_bpm,
   output logic [poxe_pkg::SPO2_W-1:0]         oxygen_percent,
   output logic                                beat_detected,
   output logic [1:0]                          alarm_kind,
   output logic                                alarm_tone_on,
   output logic                                session_done
);
   import poxe_pkg::*;

   localparam int S  = SAMPLE_BITS;
   localparam int EW = (S > 17) ? S : 17;
   localparam int PW = EW + S;
   localparam int NW = PW + 5;
   localparam int DW = (NW > TIME_W) ? NW : TIME_W;
   localparam int VW = (PW > ELAPSED_W) ? PW : ELAPSED_W;
   localparam int CW = $clog2(DW + 1);
   localparam int XW = PW + 7;

   // configuration
   logic [17:0] nf_ff;
   logic [6:0]  o2_lim_ff;
   logic [5:0]  plow_ff;
   logic [6:0]  phigh_ff;
   logic [15:0] win_ff;
   logic [11:0] hyst_ff;
   logic [7:0]  meas_ff;

   // sample being worked on
   logic [S-1:0] ir_ff, red_ff;
   logic [31:0]  now_ff;

   // session state
   logic          active_ff, armed_ff, saved_ff;
   logic [31:0]   start_ff, wstart_ff;
   logic [15:0]   beats_ff;
   logic [EW-1:0] ir_min_ff, ir_max_ff, red_min_ff, red_max_ff;
   logic [BPM_W-1:0]  bpm_ff;
   logic [SPO2_W-1:0] spo2_ff;

   // scratch and result
   logic [EW-1:0] irac_ff, redac_ff;
   logic [PW-1:0] prod_a_ff, prod_b_ff;
   logic [RECIP_W-1:0] recip_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [1:0] res_status_ff, res_alarm_ff;
   logic       res_beat_ff, res_tone_ff, res_done_ff;

   // output register
   logic [1:0]           o_status_ff, o_alarm_ff;
   logic [ELAPSED_W-1:0] o_elapsed_ff;
   logic [BPM_W-1:0]     o_bpm_ff;
   logic [SPO2_W-1:0]    o_spo2_ff;
   logic                 o_beat_ff, o_tone_ff, o_done_ff;

   // divider
   logic          div_start, div_busy;
   logic [DW-1:0] div_dvd, div_q;
   logic [VW-1:0] div_dvs;
   logic [CW-1:0] div_steps;

   logic                 no_finger, measuring, need_bpm, win_close, ac_big, spo2_sat;
   logic [31:0]          start_eff, run_ms;
   logic [31:0]          recip_arg;
   logic [RECIP_W-1:0]   recip_prod;
   logic [ELAPSED_W-1:0] elapsed_q;
   logic [EW:0]          mid;
   logic [EW+1:0]        thr;
   logic                 beat_hit;
   logic [15:0]          beats_inc;
   logic [BEAT60_W-1:0]  beat60;
   logic [EW-1:0]        ir_w, red_w, ir_ac, red_ac;
   logic [EW-1:0]        mul_a;
   logic [S-1:0]         mul_b;
   logic [PW-1:0]        prod;
   logic [NW-1:0]        num, numplus;
   logic [XW-1:0]        den104;
   poxe_alarm_type       alarm;

   assign ir_w  = EW'(ir_ff);
   assign red_w = EW'(red_ff);

   assign no_finger = 32'(ir_ff) < 32'(nf_ff);
   assign start_eff = active_ff ? start_ff : now_ff;
   assign run_ms    = now_ff - start_eff;

   // seconds and half-second phase by reciprocal multiplication
   assign recip_arg  = (cmd.op == OP_FRONT) ? run_ms : now_ff;
   assign recip_prod = RECIP_W'(64'(recip_arg) * 64'(MS_RECIP));
   assign elapsed_q  = recip_ff[SEC_SHIFT +: ELAPSED_W];
   assign measuring  = elapsed_q < ELAPSED_W'(meas_ff);
   assign need_bpm   = elapsed_q > ELAPSED_W'(BPM_MIN_S);

   assign mid      = (EW+1)'(({1'b0, ir_max_ff} + {1'b0, ir_min_ff}) >> 1);
   assign thr      = (EW+2)'(mid) + (EW+2)'(hyst_ff);
   assign beat_hit = ((EW+2)'(ir_ff) > thr) && !armed_ff;
   assign beats_inc = (beat_hit && beats_ff != 16'(BEAT_MAX)) ? beats_ff + 16'd1 : beats_ff;
   assign beat60   = BEAT60_W'(beats_inc) * BEAT60_W'(SEC_PER_MIN);

   assign win_close = (now_ff - wstart_ff) > 32'(win_ff);
   assign ir_ac     = ir_max_ff - ir_min_ff;
   assign red_ac    = red_max_ff - red_min_ff;
   assign ac_big    = ir_ac > EW'(AC_MIN);

   // one multiplier serves both cross products
   assign mul_a = (cmd.op == OP_MUL1) ? redac_ff : irac_ff;
   assign mul_b = (cmd.op == OP_MUL1) ? ir_ff : red_ff;
   assign prod  = PW'(mul_a) * PW'(mul_b);

   assign num      = (NW'(prod_a_ff) << 4) + NW'(prod_a_ff);
   assign den104   = (XW'(prod_b_ff) << 6) + (XW'(prod_b_ff) << 5) + (XW'(prod_b_ff) << 3);
   assign spo2_sat = XW'(num) >= den104;
   assign numplus  = num + NW'(prod_b_ff) - NW'(1);

   always_comb begin
      if (spo2_ff < o2_lim_ff) alarm = ALARM_LOW_O2;
      else if (bpm_ff < BPM_W'(plow_ff) || bpm_ff > BPM_W'(phigh_ff)) alarm = ALARM_PULSE;
      else alarm = ALARM_NONE;
   end

   always_comb begin
      div_start = 1'b0;
      div_dvd   = DW'(beat60) << (DW - BEAT60_W);
      div_dvs   = VW'(elapsed_q);
      div_steps = CW'(BEAT60_W);
      case (cmd.op)
         OP_EVAL: div_start = measuring && need_bpm;
         OP_CMP: begin
            div_start = !spo2_sat;
            div_dvd   = DW'(numplus) << (DW - NW);
            div_dvs   = VW'(prod_b_ff);
            div_steps = CW'(NW);
         end
         default: div_start = 1'b0;
      endcase
   end

   poxe_div #(.DW(DW), .VW(VW), .CW(CW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .steps     (div_steps),
      .busy      (div_busy),
      .quotient  (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         nf_ff      <= NO_FINGER_RST;
         o2_lim_ff  <= SPO2_LIMIT_RST;
         plow_ff    <= PULSE_LOW_RST;
         phigh_ff   <= PULSE_HIGH_RST;
         win_ff     <= WINDOW_MS_RST;
         hyst_ff    <= HYST_RST;
         meas_ff    <= MEASURE_S_RST;
      end else if (csr_write) begin
         case (poxe_reg_type'(csr_index))
            REG_NO_FINGER:  nf_ff     <= csr_data;
            REG_SPO2_LIMIT: o2_lim_ff <= csr_data[6:0];
            REG_PULSE_LOW:  plow_ff   <= csr_data[5:0];
            REG_PULSE_HIGH: phigh_ff  <= csr_data[6:0];
            REG_WINDOW_MS:  win_ff    <= csr_data[15:0];
            REG_HYSTERESIS: hyst_ff   <= csr_data[11:0];
            REG_MEASURE_S:  meas_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         armed_ff   <= 1'b0;
         saved_ff   <= 1'b0;
         start_ff   <= '0;
         wstart_ff  <= '0;
         beats_ff   <= '0;
         ir_min_ff  <= EW'(ENV_MIN_RESET);
         ir_max_ff  <= '0;
         red_min_ff <= EW'(ENV_MIN_RESET);
         red_max_ff <= '0;
         bpm_ff     <= '0;
         spo2_ff    <= '0;
      end else begin
         case (cmd.op)
            OP_FRONT: begin
               if (no_finger) begin
                  active_ff <= 1'b0;
                  saved_ff  <= 1'b0;
                  bpm_ff    <= '0;
                  spo2_ff   <= '0;
               end else if (!active_ff) begin
                  active_ff <= 1'b1;
                  start_ff  <= now_ff;
                  wstart_ff <= now_ff;
                  beats_ff  <= '0;
               end
            end
            OP_EVAL: begin
               if (measuring) begin
                  beats_ff <= beats_inc;
                  if (beat_hit) armed_ff <= 1'b1;
                  else if ((EW+1)'(ir_ff) < mid) armed_ff <= 1'b0;
                  if (red_w > red_max_ff) red_max_ff <= red_w;
                  if (red_w < red_min_ff) red_min_ff <= red_w;
                  if (ir_w > ir_max_ff) ir_max_ff <= ir_w;
                  if (ir_w < ir_min_ff) ir_min_ff <= ir_w;
               end else begin
                  saved_ff <= 1'b1;
               end
            end
            OP_BPM: bpm_ff <= (div_q > DW'(BPM_MAX)) ? BPM_W'(BPM_MAX) : div_q[BPM_W-1:0];
            OP_WIN: begin
               if (win_close) begin
                  // envelopes restart from this sample
                  ir_min_ff  <= ir_w;
                  ir_max_ff  <= ir_w;
                  red_min_ff <= red_w;
                  red_max_ff <= red_w;
                  wstart_ff  <= now_ff;
                  if (ac_big && red_ff == '0) spo2_ff <= '0;
               end
            end
            OP_CMP: if (spo2_sat) spo2_ff <= '0;
            OP_SPO2: spo2_ff <= SPO2_W'(SPO2_BASE) - div_q[SPO2_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            ir_ff  <= ir_sample;
            red_ff <= red_sample;
            now_ff <= now_ms;
         end
         OP_FRONT: begin
            recip_ff      <= recip_prod;
            res_status_ff <= ST_NO_FINGER;
            res_beat_ff   <= 1'b0;
            res_alarm_ff  <= ALARM_NONE;
            res_tone_ff   <= 1'b0;
            res_done_ff   <= 1'b0;
            elapsed_ff    <= '0;
         end
         OP_EVAL: begin
            elapsed_ff <= elapsed_q;
            if (measuring) begin
               res_status_ff <= ST_MEASURING;
               res_beat_ff   <= beat_hit;
            end else begin
               recip_ff      <= recip_prod;
               res_status_ff <= ST_FINISHED;
               res_done_ff   <= !saved_ff;
               res_alarm_ff  <= alarm;
            end
         end
         OP_WIN: begin
            irac_ff  <= ir_ac;
            redac_ff <= red_ac;
         end
         OP_MUL1: prod_a_ff <= prod;
         OP_MUL2: prod_b_ff <= prod;
         // tone is on while an alarm is raised and the count of half seconds is even
         OP_TONE: res_tone_ff <= (res_alarm_ff != ALARM_NONE) && !recip_ff[HALF_S_SHIFT];
         OP_OUT: begin
            o_status_ff  <= res_status_ff;
            o_elapsed_ff <= elapsed_ff;
            o_bpm_ff     <= bpm_ff;
            o_spo2_ff    <= spo2_ff;
            o_beat_ff    <= res_beat_ff;
            o_alarm_ff   <= res_alarm_ff;
            o_tone_ff    <= res_tone_ff;
            o_done_ff    <= res_done_ff;
         end
         default: ;
      endcase
   end

   assign stat.no_finger = no_finger;
   assign stat.measuring = measuring;
   assign stat.need_bpm  = need_bpm;
   assign stat.win_close = win_close;
   assign stat.spo2_calc = ac_big && (red_ff != '0);
   assign stat.spo2_sat  = spo2_sat;
   assign stat.div_busy  = div_busy;

   assign status          = o_status_ff;
   assign elapsed_seconds = o_elapsed_ff;
   assign pulse_bpm       = o_bpm_ff;
   assign oxygen_percent  = o_spo2_ff;
   assign beat_detected   = o_beat_ff;
   assign alarm_kind      = o_alarm_ff;
   assign alarm_tone_on   = o_tone_ff;
   assign session_done    = o_done_ff;
endmodule

// ----- src/pulse_oximeter_bpm_spo2_estimator_core.sv -----
// channel   direction  handshake     payload
// req_bus   in         valid/ready   ir_sample, red_sample, now_ms
// rsp_bus   out        valid/ready   status, elapsed, bpm, SpO2, beat, alarm, tone, done
// csr_bus   in         valid/ready   index, data (always ready)
//
// One sample at a time: without a finger it goes straight to the output; bpm is updated
// past 3 s, and SpO2 when a window closes with enough AC swing (no divide if saturated).
// Bpm and SpO2 share a radix-2 divider, one quotient bit per cycle (22 bits for bpm,
// 2*SAMPLE_BITS+5 for SpO2); seconds and tone phase come from a reciprocal multiply.
// Synchronous active-high reset loads register defaults and clears session state.
// A waiting result holds the next sample in its last step until the output frees.
module pulse_oximeter_bpm_spo2_estimator_core #(
   parameter int SAMPLE_BITS = 18
) (
   input logic        clock,
   input logic        reset,
   poxe_req_if.sink   req_bus,
   poxe_rsp_if.source rsp_bus,
   poxe_csr_if.sink   csr_bus
);
   import poxe_pkg::*;

   poxe_cmd_type  cmd;
   poxe_stat_type stat;

   assign csr_bus.ready = 1'b1;

   poxe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   poxe_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .ir_sample       (req_bus.ir_sample),
      .red_sample      (req_bus.red_sample),
      .now_ms          (req_bus.now_ms),
      .csr_write       (csr_bus.valid),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .status          (rsp_bus.status),
      .elapsed_seconds (rsp_bus.elapsed_seconds),
      .pulse_bpm       (rsp_bus.pulse_bpm),
      .oxygen_percent  (rsp_bus.oxygen_percent),
      .beat_detected   (rsp_bus.beat_detected),
      .alarm_kind      (rsp_bus.alarm_kind),
      .alarm_tone_on   (rsp_bus.alarm_tone_on),
      .session_done    (rsp_bus.session_done)
   );
endmodule
